// File: src/llb_pkg.sv
`default_nettype none
package llb_pkg;
  localparam int unsigned MAX_LINES_DEF  = 256;
  localparam int unsigned POINTS_DEF     = 1000;
  localparam int unsigned FRAC_BITS_DEF  = 24;

  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned IDX_W    = 18;
  localparam int unsigned SPEC_W   = 48;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SUM_W    = 65;
  localparam int unsigned Q_W      = 64;

  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [SPEC_W-1:0] SPEC_MAX = {SPEC_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;
endpackage
`default_nettype wire

// File: src/llb_ram.sv
`default_nettype none
module llb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// File: src/llb_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Only the low quotient bits are kept.
module llb_div #(
  parameter int unsigned NUM_W = 79
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [NUM_W-1:0]             num,
  input  wire logic [llb_pkg::SUM_W-1:0]    den,
  output llb_pkg::div_status_t              status,
  output logic      [llb_pkg::Q_W-1:0]      quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned SW = llb_pkg::SUM_W;

  logic [NUM_W-1:0] num_sh;
  logic [SW-1:0]    den_r;
  logic [SW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SW:0]      trial;
  logic             ge;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      status.done <= 1'b0;
      cnt <= '0;
    end else begin
      status.done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        num_sh <= num;
        den_r <= den;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num_sh <= num_sh << 1;
        if (ge) begin
          rem <= SW'(trial - {1'b0, den_r});
        end else begin
          rem <= trial[SW-1:0];
        end
        quo <= {quo[llb_pkg::Q_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
endmodule
`default_nettype wire

// File: src/lorentzian_line_broadening.sv
`default_nettype none
// Channel | Direction | Signals                                  | Transfer when
// in      | input     | cmd, line_freq, point_index              | in_valid && in_ready
// out     | output    | point_freq, spectrum_value, saturated    | out_valid && out_ready
// cfg     | input     | cfg_index, cfg_data                      | cfg_valid && cfg_ready
//
// Clear and load are handled in the idle state without leaving it. An evaluate
// runs the bit-serial divider once per stored line when the half width is
// nonzero (one quotient bit per cycle).
// Reset (rst, synchronous) empties the line store and restores the registers.
// The input waits while an evaluate runs; a finished result waits in the
// output register until it is taken, and the next evaluate holds at its end.
module lorentzian_line_broadening #(
  parameter int unsigned MAX_LINES       = llb_pkg::MAX_LINES_DEF,
  parameter int unsigned POINTS_PER_LINE = llb_pkg::POINTS_DEF,
  parameter int unsigned FRAC_BITS       = llb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [llb_pkg::CMD_W-1:0]       cmd,
  input  wire logic [llb_pkg::FREQ_W-1:0]      line_freq,
  input  wire logic [llb_pkg::IDX_W-1:0]       point_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [llb_pkg::FREQ_W-1:0]      point_freq,
  output logic      [llb_pkg::SPEC_W-1:0]      spectrum_value,
  output logic                                 saturated,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [llb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [llb_pkg::FREQ_W-1:0]      cfg_data
);
  localparam int unsigned FW = llb_pkg::FREQ_W;
  localparam int unsigned AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CW = $clog2(MAX_LINES + 1);
  // Numerator of each term is h*C*2^(2F), already divided by 2^32.
  localparam int unsigned FULL_W = 63 + 2 * FRAC_BITS;
  localparam int unsigned DIV_W = FULL_W - 32;
  // Software grid length; evaluates accept any index, and it is used only to block all loads when it is zero.
  localparam int unsigned GRID_HINT = POINTS_PER_LINE;

  typedef enum logic [3:0] {
    S_IDLE, S_PF, S_HH, S_HC, S_LINE, S_DIFF, S_DD, S_SUM, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic [FW-1:0] half_width, grid_step;
  logic [CW-1:0] line_count, k;
  logic [llb_pkg::IDX_W-1:0] idx;
  logic [FW-1:0] f, d;
  logic [63:0]   prod, hh, m;
  logic [FW-1:0] mul_a, mul_b;
  logic [63:0]   acc;
  logic          sat;
  logic [FW-1:0] rd_data;
  logic          rd_en;
  logic          div_start;
  logic [llb_pkg::SUM_W-1:0] s;
  logic [FULL_W-1:0] num_full;
  llb_pkg::div_status_t div_st;
  logic [llb_pkg::Q_W-1:0] quo;
  logic [63:0] term, acc_sum;
  logic        load_ok;

  // The shared multiplier; its product is always registered.
  always_comb begin
    unique case (state)
      S_PF:    begin mul_a = FW'(idx);   mul_b = grid_step; end
      S_HH:    begin mul_a = half_width; mul_b = half_width; end
      S_HC:    begin mul_a = half_width; mul_b = llb_pkg::INV_PI_Q32; end
      S_DD:    begin mul_a = d;          mul_b = d; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  assign s = {1'b0, prod} + {1'b0, hh};
  assign num_full = {m[62:0], {(2 * FRAC_BITS){1'b0}}};
  assign div_start = (state == S_SUM) && (half_width != '0);
  assign rd_en = (state == S_LINE);

  llb_div #(.NUM_W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(num_full[FULL_W-1:32]), .den(s),
    .status(div_st), .quo(quo)
  );

  assign load_ok = (line_count < CW'(MAX_LINES)) && (GRID_HINT > 0);

  llb_ram #(.WIDTH(FW), .DEPTH(MAX_LINES), .AW(AW)) u_store (
    .clk(clk),
    .wr_en(in_valid && in_ready && cmd == llb_pkg::CMD_LOAD && load_ok),
    .wr_addr(line_count[AW-1:0]), .wr_data(line_freq),
    .rd_en(rd_en), .rd_addr(k[AW-1:0]), .rd_data(rd_data)
  );

  // A zero half width gives the saturation value at distance zero only.
  always_comb begin
    if (half_width == '0) begin
      term = (d == '0) ? 64'(llb_pkg::SPEC_MAX) : 64'd0;
    end else begin
      term = quo;
    end
    acc_sum = acc + term;
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_count <= '0;
      half_width <= FW'(1);
      grid_step <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the done state the result register is refilled below instead.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == llb_pkg::REG_HALF_WIDTH) begin
          half_width <= cfg_data;
        end else if (cfg_index == llb_pkg::REG_GRID_STEP) begin
          grid_step <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == llb_pkg::CMD_CLEAR) begin
              line_count <= '0;
            end else if (cmd == llb_pkg::CMD_LOAD) begin
              if (load_ok) begin
                line_count <= line_count + 1'b1;
              end
            end else if (cmd == llb_pkg::CMD_EVAL) begin
              idx <= point_index;
              state <= S_PF;
            end
          end
        end
        S_PF: state <= S_HH;
        S_HH: begin
          // The grid frequency saturates at the top of the 32-bit range.
          if (prod[63:FW] != '0) begin
            f <= '1;
            sat <= 1'b1;
          end else begin
            f <= prod[FW-1:0];
            sat <= 1'b0;
          end
          state <= S_HC;
        end
        S_HC: begin
          hh <= prod;
          k <= '0;
          acc <= '0;
          state <= S_LINE;
        end
        S_LINE: begin
          m <= (k == '0) ? prod : m;
          state <= (k == line_count) ? S_DONE : S_DIFF;
        end
        S_DIFF: begin
          d <= (f >= rd_data) ? f - rd_data : rd_data - f;
          state <= S_DD;
        end
        S_DD: state <= S_SUM;
        S_SUM: state <= S_DIV;
        S_DIV: begin
          if (half_width == '0 || div_st.done) begin
            if (acc_sum > 64'(llb_pkg::SPEC_MAX)) begin
              acc <= 64'(llb_pkg::SPEC_MAX);
              sat <= 1'b1;
            end else begin
              acc <= acc_sum;
            end
            k <= k + 1'b1;
            state <= S_LINE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            point_freq <= f;
            spectrum_value <= acc[llb_pkg::SPEC_W-1:0];
            saturated <= sat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
